// ----- src/b64d_pkg.sv -----
// b64d_pkg: types, constants and the character table of the base64 decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package b64d_pkg;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// one input request
	typedef struct packed {
		logic [7:0] text_char;
		logic       final_char;
	} in_t;

	// one result request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       status;
		logic       end_of_run;
	} out_t;

	// status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_LEN = 1'b1;

	// classified quad handed from front to back
	typedef struct packed {
		logic        err;    // partial quad at end of message
		logic [1:0]  count;  // bytes to emit, 1..3
		logic [23:0] group;  // four sextets, oldest highest
	} grp_t;

	// character to sextet; anything outside the alphabet gives 0
	function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
		logic [5:0] s;
		s = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s = 6'd62;
		end else if (c == 8'h2F) begin
			s = 6'd63;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- src/b64d_front.sv -----
// b64d_front: takes characters, tracks the quad and classifies finished quads.
// Depends on b64d_pkg; pushes grp_t requests into b64d_queue.
`default_nettype none

module b64d_front
	import b64d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic text_valid,
	output logic      text_ready,
	input  wire in_t  text,
	input  wire logic q_full,
	output logic      q_push,
	output grp_t      q_item
);

	logic [17:0] sextet_q;
	logic [1:0]  pos_q;
	logic        pad_q;
	logic        accept;
	logic [5:0]  sx;
	logic        is_pad;
	logic [1:0]  cnt;

	assign text_ready = !q_full;
	assign accept     = text_valid && text_ready;
	assign sx         = char_to_sextet(text.text_char);
	assign is_pad     = (text.text_char == PAD_CHAR);

	// byte count: three, less one per pad in third or fourth place
	always_comb begin
		cnt = 2'd3;
		if (is_pad) cnt = cnt - 2'd1;
		if (pad_q)  cnt = cnt - 2'd1;
	end

	// push on quad end or on a final character mid-quad
	always_comb begin
		q_push = 1'b0;
		q_item = '{err: 1'b0, count: cnt, group: {sextet_q, sx}};
		if (accept) begin
			if (pos_q == 2'd3) begin
				q_push = 1'b1;
			end else if (text.final_char) begin
				q_push = 1'b1;
				q_item = '{err: 1'b1, count: 2'd1, group: 24'd0};
			end
		end
	end

	// quad state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextet_q <= '0;
			pos_q    <= '0;
			pad_q    <= 1'b0;
		end else if (accept) begin
			if (pos_q == 2'd3 || text.final_char) begin
				sextet_q <= '0;
				pos_q    <= '0;
				pad_q    <= 1'b0;
			end else begin
				sextet_q <= {sextet_q[11:0], sx};
				pos_q    <= pos_q + 2'd1;
				if (pos_q == 2'd2) pad_q <= is_pad;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/b64d_queue.sv -----
// b64d_queue: small flop-based FIFO of classified quads.
// Depends on b64d_pkg for grp_t.
`default_nettype none

module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire grp_t wr_item,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output grp_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/b64d_back.sv -----
// b64d_back: splits each queued quad into bytes, one result per cycle while the output is not stalled.
// Depends on b64d_pkg; reads the head of b64d_queue.
`default_nettype none

module b64d_back
	import b64d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_not_empty,
	input  wire grp_t q_head,
	output logic      q_pop,
	output logic      result_valid,
	input  wire logic result_ready,
	output out_t      result
);

	logic [1:0] idx_q;
	logic       valid_q;
	out_t       result_q;
	logic       fire;
	logic       last;
	logic [7:0] byte_sel;

	assign fire  = q_not_empty && (!valid_q || result_ready);
	assign last  = ((idx_q + 2'd1) == q_head.count);
	assign q_pop = fire && last;

	assign result_valid = valid_q;
	assign result       = result_q;

	// byte of the group, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = q_head.group[23:16];
			2'd1:    byte_sel = q_head.group[15:8];
			2'd2:    byte_sel = q_head.group[7:0];
			default: byte_sel = 8'd0;
		endcase
		if (q_head.err) byte_sel = 8'd0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.data_byte  <= byte_sel;
			result_q.status     <= q_head.err ? STATUS_BAD_LEN : STATUS_OK;
			result_q.end_of_run <= last;
		end
	end

	// byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/base64_decoder.sv -----
// base64_decoder: streaming base64 decoder, one character per cycle.
// A quad is queued when its fourth character is taken; then its bytes leave one per
// cycle while results are taken. Throughput: one character per cycle; a quad gives
// at most three bytes, so the back end drains faster than four characters arrive.
// Input stalls only when the quad queue (QUEUE_DEPTH entries) is full.
// Reset (arst_n low) clears quad state, queue and output valid at once.
`default_nettype none

module base64_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic text_valid,
	output logic      text_ready,
	input  wire in_t  text,
	output logic      result_valid,
	input  wire logic result_ready,
	output out_t      result
);

	logic q_full;
	logic q_push;
	grp_t q_wr;
	logic q_pop;
	logic q_not_empty;
	grp_t q_head;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_wr)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_item   (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
